// ===== rtl/scq_pkg.sv =====
// scq_pkg: types and constants for the sorted countdown wait queue
// shared by scq_cell and sorted_countdown_wait_queue_top, no dependencies
package scq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ID_W = 16;
	localparam int TIME_W = 16;
	localparam int DUR_W = 15;
	localparam int COUNT_W = 5;

	localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
	localparam logic signed [TIME_W-1:0] TIME_EMPTY = '1;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_POP   = 2'd2,
		REQ_QUERY = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_code_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [ID_W-1:0]  proc_id;
		logic [DUR_W-1:0] duration;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic                     popped_valid;
		logic [ID_W-1:0]          popped_id;
		logic signed [TIME_W-1:0] popped_time;
		logic [ID_W-1:0]          head_id;
		logic signed [TIME_W-1:0] head_time;
		logic [COUNT_W-1:0]       entry_count;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic                     push;
		logic                     tick;
		logic                     pop;
		logic [ID_W-1:0]          id;
		logic signed [TIME_W-1:0] t;
	} scq_ctl_t;

	// one cell's contents as seen by its neighbours
	typedef struct packed {
		logic                     v;
		logic                     le;
		logic [ID_W-1:0]          id;
		logic signed [TIME_W-1:0] t;
	} scq_cell_t;

endpackage

// ===== rtl/scq_cell.sv =====
// scq_cell: one queue slot, compares with the pushed time, counts down on tick and shifts with its neighbours
// depends on scq_pkg
module scq_cell import scq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  scq_ctl_t  ctl,
	input  scq_cell_t left,
	input  scq_cell_t right,
	output scq_cell_t cur,
	output scq_cell_t nxt
);

	logic                     v_q;
	logic [ID_W-1:0]          id_q;
	logic signed [TIME_W-1:0] t_q;

	always_comb begin
		cur.v  = v_q;
		cur.id = id_q;
		cur.t  = t_q;
		cur.le = v_q && (t_q <= ctl.t);
	end

	always_comb begin
		nxt = cur;
		if (ctl.push) begin
			if (!cur.le) begin
				if (left.le) begin
					nxt.id = ctl.id;
					nxt.t  = ctl.t;
				end else begin
					nxt.id = left.id;
					nxt.t  = left.t;
				end
				nxt.v = cur.v | left.v;
			end
		end else if (ctl.tick) begin
			if (cur.t != TIME_MIN) begin
				nxt.t = cur.t - 16'sd1;
			end
		end else if (ctl.pop) begin
			nxt.v  = right.v;
			nxt.id = right.id;
			nxt.t  = right.t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= nxt.v;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= nxt.id;
		t_q  <= nxt.t;
	end

endmodule

// ===== rtl/sorted_countdown_wait_queue_top.sv =====
// sorted_countdown_wait_queue_top: row of scq_cell slots plus count and result register
// depends on scq_pkg and scq_cell
//
// Usage: a request beat is taken at a rising edge with start high and busy low.
// req carries req_type (push, tick, pop, query), proc_id and duration.
// Exactly one result beat follows per request: done is high for one cycle,
// the cycle right after the request edge, with rsp holding status, the popped
// entry (if any), the head after the request and the entry count.
// A new request may be given every cycle: every slot
// compares, decrements or shifts in parallel with its neighbours, so push,
// tick and pop each settle at the clock edge that takes the request.
// busy is always low.
// Reset empties the queue (all slot valid bits cleared) and drops done.
// The receiver cannot stall: done marks each result beat for one cycle only.
module sorted_countdown_wait_queue_top import scq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	logic             accept;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             full;
	logic             done_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	scq_ctl_t         ctl;
	scq_cell_t        cur [DEPTH];
	scq_cell_t        nxt [DEPTH];
	scq_cell_t        edge_left;
	scq_cell_t        edge_right;
	logic [DEPTH-1:0] v_vec;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));

	assign edge_left  = '{v: 1'b1, le: 1'b1, id: '0, t: '0};
	assign edge_right = '{v: 1'b0, le: 1'b0, id: '0, t: '0};

	always_comb begin
		ctl.push = accept && (req_code_t'(req.req_type) == REQ_PUSH) && !full;
		ctl.tick = accept && (req_code_t'(req.req_type) == REQ_TICK);
		ctl.pop  = accept && (req_code_t'(req.req_type) == REQ_POP) && cur[0].v;
		ctl.id   = req.proc_id;
		ctl.t    = signed'({1'b0, req.duration});
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		scq_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.left  ((k == 0) ? edge_left : cur[(k == 0) ? 0 : k - 1]),
			.right ((k == DEPTH - 1) ? edge_right : cur[(k == DEPTH - 1) ? k : k + 1]),
			.cur   (cur[k]),
			.nxt   (nxt[k])
		);
		assign v_vec[k] = cur[k].v;
	end

	always_comb begin
		count_d = count_q;
		if (ctl.push) begin
			count_d = count_q + 1'b1;
		end else if (ctl.pop) begin
			count_d = count_q - 1'b1;
		end
	end

	always_comb begin
		rsp_d              = '0;
		rsp_d.status       = ST_OK;
		if ((req_code_t'(req.req_type) == REQ_PUSH) && full) begin
			rsp_d.status = ST_FULL;
		end else if ((req_code_t'(req.req_type) == REQ_POP) && !cur[0].v) begin
			rsp_d.status = ST_EMPTY;
		end
		if (ctl.pop) begin
			rsp_d.popped_valid = 1'b1;
			rsp_d.popped_id    = cur[0].id;
			rsp_d.popped_time  = cur[0].t;
		end
		if (nxt[0].v) begin
			rsp_d.head_id   = nxt[0].id;
			rsp_d.head_time = nxt[0].t;
		end else begin
			rsp_d.head_time = TIME_EMPTY;
		end
		rsp_d.entry_count = COUNT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_one_beat_per_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request without result beat");

	a_no_spurious_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result beat without request");

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(v_vec) == 32'(count_q))
		else $error("count differs from valid slots");

	a_slots_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(v_vec & ~{v_vec[DEPTH-2:0], 1'b1}) == '0)
		else $error("hole in slot row");

	a_pop_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.popped_valid) |-> (status_code_t'(rsp.status) == ST_OK))
		else $error("popped entry with error status");

endmodule
